// ----- design/plob_pkg.sv -----
// Shared constants, codes and control types of the price level order book.
package plob_pkg;

   // Default sizes of the book.
   localparam int LEVELS_DEF      = 64;
   localparam int PRICE_BITS_DEF  = 32;
   localparam int VOLUME_BITS_DEF = 32;

   // Width of the running volume totals, which wrap.
   localparam int TOTAL_BITS = 38;

   // Width of the imbalance quotient in Q1.15.
   localparam int QUO_BITS = 16;

   // Command codes.
   localparam logic [2:0] CMD_SET_BID    = 3'd0;
   localparam logic [2:0] CMD_SET_ASK    = 3'd1;
   localparam logic [2:0] CMD_CLEAR_BIDS = 3'd2;
   localparam logic [2:0] CMD_CLEAR_ASKS = 3'd3;
   localparam logic [2:0] CMD_CLEAR_ALL  = 3'd4;

   // Status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_PRICE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Control broadcast to every cell of one side.
   typedef struct packed {
      logic clear;
      logic wr_en;
      logic wr_used;
   } plob_ctl_type;

endpackage

// ----- design/plob_if.sv -----
// Handshake channels for command items and result items.
interface plob_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [31:0] level_price;
   logic [31:0] level_volume;

   modport source (output valid, command, level_price, level_volume, input ready);
   modport sink (input valid, command, level_price, level_volume, output ready);
endinterface

interface plob_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               bid_present;
   logic [31:0]        top_bid;
   logic               ask_present;
   logic [31:0]        top_ask;
   logic [32:0]        mid_doubled;
   logic signed [32:0] bid_ask_gap;
   logic [37:0]        bid_volume_sum;
   logic [37:0]        ask_volume_sum;
   logic signed [15:0] volume_imbalance;

   modport source (output valid, status, bid_present, top_bid, ask_present, top_ask,
                   mid_doubled, bid_ask_gap, bid_volume_sum, ask_volume_sum,
                   volume_imbalance, input ready);
   modport sink (input valid, status, bid_present, top_bid, ask_present, top_ask,
                 mid_doubled, bid_ask_gap, bid_volume_sum, ask_volume_sum,
                 volume_imbalance, output ready);
endinterface

// ----- design/plob_cell.sv -----
// One price level slot with its stage of the search chain.
module plob_cell import plob_pkg::*; #(
   parameter int PRICE_BITS  = PRICE_BITS_DEF,
   parameter int VOLUME_BITS = VOLUME_BITS_DEF,
   parameter int IDX_BITS    = 6,
   parameter int IDX         = 0,
   parameter bit WANT_HIGH   = 1'b1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  plob_ctl_type           ctl,
   input  logic [IDX_BITS-1:0]    wr_idx,
   input  logic [PRICE_BITS-1:0]  wr_price,
   input  logic [VOLUME_BITS-1:0] wr_volume,
   input  logic [PRICE_BITS-1:0]  key_price,
   input  logic                   in_found,
   input  logic [PRICE_BITS-1:0]  in_best,
   input  logic                   in_hit,
   input  logic [IDX_BITS-1:0]    in_hit_idx,
   input  logic [VOLUME_BITS-1:0] in_hit_volume,
   input  logic                   in_free,
   input  logic [IDX_BITS-1:0]    in_free_idx,
   output logic                   out_found,
   output logic [PRICE_BITS-1:0]  out_best,
   output logic                   out_hit,
   output logic [IDX_BITS-1:0]    out_hit_idx,
   output logic [VOLUME_BITS-1:0] out_hit_volume,
   output logic                   out_free,
   output logic [IDX_BITS-1:0]    out_free_idx
);

   logic                   used_ff;
   logic [PRICE_BITS-1:0]  price_ff;
   logic [VOLUME_BITS-1:0] volume_ff;

   logic                   found_in;
   logic [PRICE_BITS-1:0]  best_in;
   logic                   hit_in;
   logic [IDX_BITS-1:0]    hit_idx_in;
   logic [VOLUME_BITS-1:0] hit_volume_in;
   logic                   free_in;
   logic [IDX_BITS-1:0]    free_idx_in;
   logic                   better;
   logic                   mine;

   assign mine = (wr_idx == IDX_BITS'(IDX));

   // Slot storage: clearing drops the used bit only.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         used_ff <= 1'b0;
      end else if (ctl.wr_en && mine) begin
         used_ff <= ctl.wr_used;
      end
      if (ctl.wr_en && mine) begin
         price_ff  <= wr_price;
         volume_ff <= wr_volume;
      end
   end

   // Fold this slot into the item passing along the chain.
   always_comb begin
      better        = WANT_HIGH ? (price_ff > in_best) : (price_ff < in_best);
      found_in      = in_found | used_ff;
      best_in       = (used_ff && (!in_found || better)) ? price_ff : in_best;
      hit_in        = in_hit | (used_ff && (price_ff == key_price));
      hit_idx_in    = in_hit ? in_hit_idx : IDX_BITS'(IDX);
      hit_volume_in = in_hit ? in_hit_volume : volume_ff;
      free_in       = in_free | ~used_ff;
      free_idx_in   = in_free ? in_free_idx : IDX_BITS'(IDX);
   end

   // Chain stage register.
   always_ff @(posedge clock) begin
      out_found      <= found_in;
      out_best       <= best_in;
      out_hit        <= hit_in;
      out_hit_idx    <= hit_idx_in;
      out_hit_volume <= hit_volume_in;
      out_free       <= free_in;
      out_free_idx   <= free_idx_in;
   end

endmodule

// ----- design/plob_chain.sv -----
// Row of slots for one side of the book, searched by a travelling item.
module plob_chain import plob_pkg::*; #(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int PRICE_BITS  = PRICE_BITS_DEF,
   parameter int VOLUME_BITS = VOLUME_BITS_DEF,
   parameter bit WANT_HIGH   = 1'b1,
   localparam int IDX_BITS   = $clog2(LEVELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  plob_ctl_type           ctl,
   input  logic [IDX_BITS-1:0]    wr_idx,
   input  logic [PRICE_BITS-1:0]  wr_price,
   input  logic [VOLUME_BITS-1:0] wr_volume,
   input  logic [PRICE_BITS-1:0]  key_price,
   output logic                   found,
   output logic [PRICE_BITS-1:0]  best,
   output logic                   hit,
   output logic [IDX_BITS-1:0]    hit_idx,
   output logic [VOLUME_BITS-1:0] hit_volume,
   output logic                   free,
   output logic [IDX_BITS-1:0]    free_idx
);

   logic                   found_w      [0:LEVELS];
   logic [PRICE_BITS-1:0]  best_w       [0:LEVELS];
   logic                   hit_w        [0:LEVELS];
   logic [IDX_BITS-1:0]    hit_idx_w    [0:LEVELS];
   logic [VOLUME_BITS-1:0] hit_volume_w [0:LEVELS];
   logic                   free_w       [0:LEVELS];
   logic [IDX_BITS-1:0]    free_idx_w   [0:LEVELS];

   // The item enters the first cell empty.
   assign found_w[0]      = 1'b0;
   assign best_w[0]       = '0;
   assign hit_w[0]        = 1'b0;
   assign hit_idx_w[0]    = '0;
   assign hit_volume_w[0] = '0;
   assign free_w[0]       = 1'b0;
   assign free_idx_w[0]   = '0;

   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      plob_cell #(
         .PRICE_BITS (PRICE_BITS),
         .VOLUME_BITS(VOLUME_BITS),
         .IDX_BITS   (IDX_BITS),
         .IDX        (i),
         .WANT_HIGH  (WANT_HIGH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .wr_idx        (wr_idx),
         .wr_price      (wr_price),
         .wr_volume     (wr_volume),
         .key_price     (key_price),
         .in_found      (found_w[i]),
         .in_best       (best_w[i]),
         .in_hit        (hit_w[i]),
         .in_hit_idx    (hit_idx_w[i]),
         .in_hit_volume (hit_volume_w[i]),
         .in_free       (free_w[i]),
         .in_free_idx   (free_idx_w[i]),
         .out_found     (found_w[i+1]),
         .out_best      (best_w[i+1]),
         .out_hit       (hit_w[i+1]),
         .out_hit_idx   (hit_idx_w[i+1]),
         .out_hit_volume(hit_volume_w[i+1]),
         .out_free      (free_w[i+1]),
         .out_free_idx  (free_idx_w[i+1])
      );
   end

   assign found      = found_w[LEVELS];
   assign best       = best_w[LEVELS];
   assign hit        = hit_w[LEVELS];
   assign hit_idx    = hit_idx_w[LEVELS];
   assign hit_volume = hit_volume_w[LEVELS];
   assign free       = free_w[LEVELS];
   assign free_idx   = free_idx_w[LEVELS];

endmodule

// ----- design/price_level_order_book.sv -----
// Top level of the price level order book: sequencer, totals and imbalance divider.
//
//  channel  role  handshake    payload
//  req      in    valid/ready  command, level_price, level_volume
//  rsp      out   valid/ready  status, best prices, mid, gap, totals, imbalance
//
// A set command searches the chain twice, once to find its level and once for the best
// prices; a clear or rejected command searches it once. Each pass must ripple through
// the chain of LEVELS slot cells, and the imbalance needs a 16 step restoring divider.
// The sequencer returns to idle before the next item is taken.
// Reset is synchronous and empties both sides at once. One item is in work at a
// time; a finished result waits in the output register while the next item is taken.
module price_level_order_book import plob_pkg::*; #(
   parameter int LEVELS      = LEVELS_DEF,
   parameter int PRICE_BITS  = PRICE_BITS_DEF,
   parameter int VOLUME_BITS = VOLUME_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   plob_req_if.sink  req_chan,
   plob_rsp_if.source rsp_chan
);

   localparam int IDX_BITS = $clog2(LEVELS);
   localparam int CNT_BITS = ($clog2(LEVELS) > 4) ? $clog2(LEVELS) : 4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_FIND, ST_APPLY, ST_BEST, ST_PREP, ST_DIV, ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [2:0]             cmd_ff;
   logic [PRICE_BITS-1:0]  price_ff;
   logic [VOLUME_BITS-1:0] volume_ff;
   logic [1:0]             status_ff;
   logic [TOTAL_BITS-1:0]  bid_total_ff;
   logic [TOTAL_BITS-1:0]  ask_total_ff;
   logic                   bid_found_ff;
   logic                   ask_found_ff;
   logic [31:0]            bid_best_ff;
   logic [31:0]            ask_best_ff;
   logic                   zero_ff;
   logic                   neg_ff;
   logic [TOTAL_BITS+2:0]  rem_ff;
   logic [15:0]            low_ff;
   logic [TOTAL_BITS+1:0]  dvs_ff;
   logic [QUO_BITS-1:0]    quo_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             out_status_ff;
   logic                   out_bid_present_ff;
   logic [31:0]            out_top_bid_ff;
   logic                   out_ask_present_ff;
   logic [31:0]            out_top_ask_ff;
   logic [32:0]            out_mid_ff;
   logic [32:0]            out_gap_ff;
   logic [TOTAL_BITS-1:0]  out_bid_sum_ff;
   logic [TOTAL_BITS-1:0]  out_ask_sum_ff;
   logic [15:0]            out_imb_ff;

   plob_ctl_type           bid_ctl;
   plob_ctl_type           ask_ctl;
   logic [IDX_BITS-1:0]    wr_idx;

   logic                   bid_found, ask_found, bid_hit, ask_hit, bid_free, ask_free;
   logic [PRICE_BITS-1:0]  bid_best, ask_best;
   logic [IDX_BITS-1:0]    bid_hit_idx, ask_hit_idx, bid_free_idx, ask_free_idx;
   logic [VOLUME_BITS-1:0] bid_hit_vol, ask_hit_vol;

   logic                   is_bid;
   logic                   is_set;
   logic                   sel_hit;
   logic                   sel_free;
   logic [IDX_BITS-1:0]    sel_hit_idx;
   logic [IDX_BITS-1:0]    sel_free_idx;
   logic [VOLUME_BITS-1:0] sel_hit_vol;
   logic                   vol_nz;
   logic                   apply_wr;
   logic [TOTAL_BITS-1:0]  side_total;
   logic [TOTAL_BITS-1:0]  new_total;
   logic                   clear_bid;
   logic                   clear_ask;
   logic [TOTAL_BITS:0]    sum_t;
   logic [TOTAL_BITS-1:0]  diff_d;
   logic [TOTAL_BITS+2:0]  rem_shift;
   logic [TOTAL_BITS+2:0]  rem_sub;
   logic [QUO_BITS-1:0]    imb_q;

   // Selection of the side that a set command addresses.
   always_comb begin
      is_bid       = (cmd_ff == CMD_SET_BID);
      is_set       = (cmd_ff == CMD_SET_BID) || (cmd_ff == CMD_SET_ASK);
      sel_hit      = is_bid ? bid_hit : ask_hit;
      sel_free     = is_bid ? bid_free : ask_free;
      sel_hit_idx  = is_bid ? bid_hit_idx : ask_hit_idx;
      sel_free_idx = is_bid ? bid_free_idx : ask_free_idx;
      sel_hit_vol  = is_bid ? bid_hit_vol : ask_hit_vol;
      side_total   = is_bid ? bid_total_ff : ask_total_ff;
      vol_nz       = (volume_ff != '0);
      apply_wr     = sel_hit || (vol_nz && sel_free);
      wr_idx       = sel_hit ? sel_hit_idx : sel_free_idx;
      new_total    = side_total - (sel_hit ? TOTAL_BITS'(sel_hit_vol) : '0)
                     + (vol_nz ? TOTAL_BITS'(volume_ff) : '0);
      clear_bid    = (state_ff == ST_DECODE)
                     && ((cmd_ff == CMD_CLEAR_BIDS) || (cmd_ff == CMD_CLEAR_ALL));
      clear_ask    = (state_ff == ST_DECODE)
                     && ((cmd_ff == CMD_CLEAR_ASKS) || (cmd_ff == CMD_CLEAR_ALL));
      bid_ctl.clear   = clear_bid;
      bid_ctl.wr_en   = (state_ff == ST_APPLY) && is_bid && apply_wr;
      bid_ctl.wr_used = vol_nz;
      ask_ctl.clear   = clear_ask;
      ask_ctl.wr_en   = (state_ff == ST_APPLY) && (cmd_ff == CMD_SET_ASK) && apply_wr;
      ask_ctl.wr_used = vol_nz;
   end

   // Divider set-up and one restoring step.
   always_comb begin
      sum_t     = {1'b0, bid_total_ff} + {1'b0, ask_total_ff};
      diff_d    = (ask_total_ff > bid_total_ff) ? (ask_total_ff - bid_total_ff)
                                                : (bid_total_ff - ask_total_ff);
      rem_shift = {rem_ff[TOTAL_BITS+1:0], low_ff[15]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      if (zero_ff) begin
         imb_q = '0;
      end else if (neg_ff) begin
         imb_q = QUO_BITS'(0) - ((quo_ff > 16'd32768) ? 16'd32768 : quo_ff);
      end else begin
         imb_q = (quo_ff > 16'd32767) ? 16'd32767 : quo_ff;
      end
   end

   plob_chain #(
      .LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .VOLUME_BITS(VOLUME_BITS), .WANT_HIGH(1'b1)
   ) u_bid (
      .clock(clock), .reset(reset), .ctl(bid_ctl), .wr_idx(wr_idx),
      .wr_price(price_ff), .wr_volume(volume_ff), .key_price(price_ff),
      .found(bid_found), .best(bid_best), .hit(bid_hit), .hit_idx(bid_hit_idx),
      .hit_volume(bid_hit_vol), .free(bid_free), .free_idx(bid_free_idx)
   );

   plob_chain #(
      .LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .VOLUME_BITS(VOLUME_BITS), .WANT_HIGH(1'b0)
   ) u_ask (
      .clock(clock), .reset(reset), .ctl(ask_ctl), .wr_idx(wr_idx),
      .wr_price(price_ff), .wr_volume(volume_ff), .key_price(price_ff),
      .found(ask_found), .best(ask_best), .hit(ask_hit), .hit_idx(ask_hit_idx),
      .hit_volume(ask_hit_vol), .free(ask_free), .free_idx(ask_free_idx)
   );

   // Sequencer, totals and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bid_total_ff <= '0;
         ask_total_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         // The result register is loaded when finished and free, and emptied when taken.
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff    <= req_chan.command;
                  price_ff  <= PRICE_BITS'(req_chan.level_price);
                  volume_ff <= VOLUME_BITS'(req_chan.level_volume);
                  state_ff  <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               cnt_ff    <= '0;
               status_ff <= (is_set && price_ff == '0) ? STAT_PRICE : STAT_OK;
               state_ff  <= (is_set && price_ff != '0) ? ST_FIND : ST_BEST;
               case (cmd_ff)
                  CMD_CLEAR_BIDS: bid_total_ff <= '0;
                  CMD_CLEAR_ASKS: ask_total_ff <= '0;
                  CMD_CLEAR_ALL: begin
                     bid_total_ff <= '0;
                     ask_total_ff <= '0;
                  end
                  default: ;
               endcase
            end
            ST_FIND: begin
               if (cnt_ff == CNT_BITS'(LEVELS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_APPLY;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_APPLY: begin
               if (apply_wr) begin
                  if (is_bid) begin
                     bid_total_ff <= new_total;
                  end else begin
                     ask_total_ff <= new_total;
                  end
               end else if (vol_nz) begin
                  status_ff <= STAT_FULL;
               end
               state_ff <= ST_BEST;
            end
            ST_BEST: begin
               if (cnt_ff == CNT_BITS'(LEVELS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_PREP;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_PREP: begin
               bid_found_ff <= bid_found;
               ask_found_ff <= ask_found;
               bid_best_ff  <= 32'(bid_best);
               ask_best_ff  <= 32'(ask_best);
               zero_ff      <= (sum_t == '0);
               neg_ff       <= (ask_total_ff > bid_total_ff);
               rem_ff       <= (TOTAL_BITS+3)'(diff_d) + (TOTAL_BITS+3)'(sum_t[TOTAL_BITS:16]);
               low_ff       <= sum_t[15:0];
               dvs_ff       <= {sum_t, 1'b0};
               quo_ff       <= '0;
               cnt_ff       <= '0;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (!rem_sub[TOTAL_BITS+2]) begin
                  rem_ff <= rem_sub;
                  quo_ff <= {quo_ff[QUO_BITS-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift;
                  quo_ff <= {quo_ff[QUO_BITS-2:0], 1'b0};
               end
               low_ff <= {low_ff[14:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  out_status_ff      <= status_ff;
                  out_bid_present_ff <= bid_found_ff;
                  out_top_bid_ff     <= bid_best_ff;
                  out_ask_present_ff <= ask_found_ff;
                  out_top_ask_ff     <= ask_best_ff;
                  out_mid_ff         <= (bid_found_ff && ask_found_ff)
                                        ? ({1'b0, bid_best_ff} + {1'b0, ask_best_ff}) : '0;
                  out_gap_ff         <= (bid_found_ff && ask_found_ff)
                                        ? ({1'b0, ask_best_ff} - {1'b0, bid_best_ff}) : '0;
                  out_bid_sum_ff     <= bid_total_ff;
                  out_ask_sum_ff     <= ask_total_ff;
                  out_imb_ff         <= imb_q;
                  state_ff           <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = out_status_ff;
   assign rsp_chan.bid_present      = out_bid_present_ff;
   assign rsp_chan.top_bid          = out_top_bid_ff;
   assign rsp_chan.ask_present      = out_ask_present_ff;
   assign rsp_chan.top_ask          = out_top_ask_ff;
   assign rsp_chan.mid_doubled      = out_mid_ff;
   assign rsp_chan.bid_ask_gap      = $signed(out_gap_ff);
   assign rsp_chan.bid_volume_sum   = out_bid_sum_ff;
   assign rsp_chan.ask_volume_sum   = out_ask_sum_ff;
   assign rsp_chan.volume_imbalance = $signed(out_imb_ff);

   // Slots are written only while a set command is applied.
   a_write_in_apply: assert property (@(posedge clock) disable iff (reset)
      (bid_ctl.wr_en || ask_ctl.wr_en) |-> (state_ff == ST_APPLY))
      else $error("slot write outside the apply step");

   // Clearing both sides leaves both totals at zero.
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && cmd_ff == CMD_CLEAR_ALL) |=>
      (bid_total_ff == '0 && ask_total_ff == '0))
      else $error("totals not zero after clearing both sides");

   // A full side can only be reported for a set command.
   a_full_on_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && status_ff == STAT_FULL) |->
      (cmd_ff == CMD_SET_BID || cmd_ff == CMD_SET_ASK))
      else $error("full status without a set command");

   // A finished item is presented on the result channel.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("result item not presented");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the price level order book: commands in, book views checked.
`timescale 1ns / 100ps

module testbench;
   import plob_pkg::*;

   localparam int NUM_LEVELS   = LEVELS_DEF;
   localparam int SETTLE_TICKS = 2 * NUM_LEVELS + 60;
   localparam int RANDOM_ITEMS = 420;

   // One expected book view, as the block reports it after a command.
   typedef struct {
      logic [1:0]         status;
      logic               bid_present;
      logic [31:0]        top_bid;
      logic               ask_present;
      logic [31:0]        top_ask;
      logic [32:0]        mid_doubled;
      logic signed [32:0] bid_ask_gap;
      logic [37:0]        bid_volume_sum;
      logic [37:0]        ask_volume_sum;
      logic signed [15:0] volume_imbalance;
   } book_view_type;

   typedef enum int {SIDE_BID = 0, SIDE_ASK = 1} book_side_type;

   logic clock;
   logic reset;
   int   error_count;
   int   burst_left;
   int   stall_pct;

   // Shadow copy of both price tables.
   logic [31:0] shadow_price [2][NUM_LEVELS];
   logic [31:0] shadow_volume[2][NUM_LEVELS];
   logic        shadow_used  [2][NUM_LEVELS];
   logic [37:0] shadow_total [2];

   book_view_type pending_views[$];

   plob_req_if req_chan();
   plob_rsp_if rsp_chan();

   price_level_order_book u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit.
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Empties one side of the shadow book.
   function automatic void shadow_clear(book_side_type s);
      for (int i = 0; i < NUM_LEVELS; i++) begin
         shadow_used[s][i]   = 1'b0;
         shadow_price[s][i]  = '0;
         shadow_volume[s][i] = '0;
      end
      shadow_total[s] = '0;
   endfunction

   // Applies a set command to one side and returns its status.
   function automatic logic [1:0] shadow_set(book_side_type s, logic [31:0] p, logic [31:0] v);
      int hit;
      int free_slot;
      hit       = -1;
      free_slot = -1;
      if (p == 0) return STAT_PRICE;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (shadow_used[s][i]) begin
            if (hit < 0 && shadow_price[s][i] == p) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit >= 0) begin
         shadow_total[s] = shadow_total[s] - shadow_volume[s][hit];
         if (v == 0) begin
            shadow_used[s][hit]   = 1'b0;
            shadow_volume[s][hit] = '0;
         end else begin
            shadow_volume[s][hit] = v;
            shadow_total[s]       = shadow_total[s] + v;
         end
         return STAT_OK;
      end
      if (v == 0) return STAT_OK;
      if (free_slot < 0) return STAT_FULL;
      shadow_used[s][free_slot]   = 1'b1;
      shadow_price[s][free_slot]  = p;
      shadow_volume[s][free_slot] = v;
      shadow_total[s]             = shadow_total[s] + v;
      return STAT_OK;
   endfunction

   // Q1.15 imbalance of the two totals, rounded half away from zero and clamped.
   function automatic logic signed [15:0] imbalance_of(logic [37:0] b, logic [37:0] a);
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] q;
      t = 64'(b) + 64'(a);
      if (t == 0) return '0;
      d = (a > b) ? 64'(a - b) : 64'(b - a);
      q = ((d << 16) + t) / (t << 1);
      if (a > b) begin
         if (q > 32768) q = 32768;
         return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   // Applies one command to the shadow book and returns the view it should produce.
   function automatic book_view_type book_update(logic [2:0] c, logic [31:0] p, logic [31:0] v);
      book_view_type w;
      w = '{default: '0};
      w.status = STAT_OK;
      case (c)
         CMD_SET_BID:    w.status = shadow_set(SIDE_BID, p, v);
         CMD_SET_ASK:    w.status = shadow_set(SIDE_ASK, p, v);
         CMD_CLEAR_BIDS: shadow_clear(SIDE_BID);
         CMD_CLEAR_ASKS: shadow_clear(SIDE_ASK);
         CMD_CLEAR_ALL: begin
            shadow_clear(SIDE_BID);
            shadow_clear(SIDE_ASK);
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (shadow_used[SIDE_BID][i] &&
             (!w.bid_present || shadow_price[SIDE_BID][i] > w.top_bid)) begin
            w.top_bid     = shadow_price[SIDE_BID][i];
            w.bid_present = 1'b1;
         end
         if (shadow_used[SIDE_ASK][i] &&
             (!w.ask_present || shadow_price[SIDE_ASK][i] < w.top_ask)) begin
            w.top_ask     = shadow_price[SIDE_ASK][i];
            w.ask_present = 1'b1;
         end
      end
      if (w.bid_present && w.ask_present) begin
         w.mid_doubled = 33'(w.top_bid) + 33'(w.top_ask);
         w.bid_ask_gap = 33'(w.top_ask) - 33'(w.top_bid);
      end
      w.bid_volume_sum   = shadow_total[SIDE_BID];
      w.ask_volume_sum   = shadow_total[SIDE_ASK];
      w.volume_imbalance = imbalance_of(shadow_total[SIDE_BID], shadow_total[SIDE_ASK]);
      return w;
   endfunction

   // Prints one mismatch and counts it.
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      error_count++;
   endtask

   // Result checker: each accepted view is compared with the oldest expectation.
   always @(posedge clock) begin
      book_view_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_views.size() == 0) begin
            $display("%0t: result item with no expectation waiting", $realtime);
            error_count++;
         end else begin
            w = pending_views.pop_front();
            if (rsp_chan.status !== w.status)
               report_mismatch("status", 64'(rsp_chan.status), 64'(w.status));
            if (rsp_chan.bid_present !== w.bid_present)
               report_mismatch("bid_present", 64'(rsp_chan.bid_present),
                               64'(w.bid_present));
            if (rsp_chan.top_bid !== w.top_bid)
               report_mismatch("top_bid", 64'(rsp_chan.top_bid), 64'(w.top_bid));
            if (rsp_chan.ask_present !== w.ask_present)
               report_mismatch("ask_present", 64'(rsp_chan.ask_present),
                               64'(w.ask_present));
            if (rsp_chan.top_ask !== w.top_ask)
               report_mismatch("top_ask", 64'(rsp_chan.top_ask), 64'(w.top_ask));
            if (rsp_chan.mid_doubled !== w.mid_doubled)
               report_mismatch("mid_doubled", 64'(rsp_chan.mid_doubled),
                               64'(w.mid_doubled));
            if (rsp_chan.bid_ask_gap !== w.bid_ask_gap)
               report_mismatch("bid_ask_gap", 64'(rsp_chan.bid_ask_gap),
                               64'(w.bid_ask_gap));
            if (rsp_chan.bid_volume_sum !== w.bid_volume_sum)
               report_mismatch("bid_volume_sum", 64'(rsp_chan.bid_volume_sum),
                               64'(w.bid_volume_sum));
            if (rsp_chan.ask_volume_sum !== w.ask_volume_sum)
               report_mismatch("ask_volume_sum", 64'(rsp_chan.ask_volume_sum),
                               64'(w.ask_volume_sum));
            if (rsp_chan.volume_imbalance !== w.volume_imbalance)
               report_mismatch("volume_imbalance", 64'(rsp_chan.volume_imbalance),
                               64'(w.volume_imbalance));
         end
      end
   end

   // Receiver back-pressure: the stall rate changes at random times, sometimes to none.
   initial begin
      rsp_chan.ready <= 1'b0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               2:       stall_pct = 70;
               default: stall_pct = 95;
            endcase
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Sends one command item in bursts with random gaps, and records its expected view.
   task automatic send_order(logic [2:0] c, logic [31:0] p, logic [31:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= c;
      req_chan.level_price  <= p;
      req_chan.level_volume <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_views.push_back(book_update(c, p, v));
      burst_left--;
   endtask

   // Holds the sender back until every expected result has arrived.
   task automatic wait_book_idle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Edge values of the fields, every command and the named special cases.
   task automatic test_directed();
      send_order(CMD_SET_BID, 32'd0, 32'd5);
      send_order(CMD_SET_ASK, 32'd0, 32'd0);
      send_order(CMD_SET_BID, 32'd100, 32'd10);
      send_order(CMD_SET_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(CMD_SET_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(CMD_SET_BID, 32'd100, 32'd20);
      send_order(CMD_SET_BID, 32'd555, 32'd0);
      send_order(CMD_SET_BID, 32'd100, 32'd0);
      send_order(CMD_SET_ASK, 32'd1, 32'd1);
      send_order(CMD_SET_ASK, 32'd2, 32'h8000_0000);
      send_order(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(3'd6, 32'h5555_5555, 32'hAAAA_AAAA);
      send_order(3'd7, 32'd0, 32'd0);
      send_order(CMD_CLEAR_BIDS, 32'hAAAA_AAAA, 32'h5555_5555);
      send_order(CMD_SET_BID, 32'd7, 32'd3);
      send_order(CMD_CLEAR_ASKS, 32'hFFFF_FFFF, 32'd0);
      send_order(CMD_SET_ASK, 32'd9, 32'd1);
      send_order(CMD_CLEAR_ALL, 32'h1234_5678, 32'hFFFF_FFFF);
      send_order(CMD_SET_ASK, 32'h8000_0000, 32'd1);
   endtask

   // Fills each side to capacity, overflows it, then updates and frees levels at the limit.
   task automatic test_full_sides();
      for (int s = 0; s < 2; s++) begin
         logic [2:0] c;
         c = (s == 0) ? CMD_SET_BID : CMD_SET_ASK;
         for (int i = 0; i < NUM_LEVELS; i++)
            send_order(c, 32'(5000 + 3 * i), (s == 0) ? $urandom : 32'hFFFF_FFFF);
         send_order(c, 32'd4000, 32'd77);
         send_order(c, 32'd5000 + 32'd30, 32'd12);
         send_order(c, 32'd5000 + 32'd30, 32'd0);
         send_order(c, 32'd4000, 32'd77);
         send_order(c, 32'd4001, 32'd78);
         send_order(c, 32'd4001, 32'd0);
      end
      // Pause here until the book has answered everything.
      wait_book_idle();
      send_order(CMD_CLEAR_ALL, $urandom, $urandom);
   endtask

   // Random commands, mostly well-formed sets on a narrow price band so levels are hit.
   task automatic test_random_book();
      logic [2:0]  c;
      logic [31:0] p;
      logic [31:0] v;
      int          pick;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 44)      c = CMD_SET_BID;
         else if (pick < 88) c = CMD_SET_ASK;
         else if (pick < 91) c = CMD_CLEAR_BIDS;
         else if (pick < 94) c = CMD_CLEAR_ASKS;
         else if (pick < 96) c = CMD_CLEAR_ALL;
         else                c = 3'($urandom_range(5, 7));
         pick = $urandom_range(0, 99);
         if (pick < 8)       p = 32'd0;
         else if (pick < 80) p = (c == CMD_SET_ASK) ? $urandom_range(1020, 1070)
                                                    : $urandom_range(990, 1040);
         else                p = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 18)      v = 32'd0;
         else if (pick < 75) v = $urandom_range(1, 1000);
         else                v = $urandom;
         send_order(c, p, v);
         if (n == RANDOM_ITEMS / 2) wait_book_idle();
      end
   endtask

   // Test sequence.
   initial begin
      error_count = 0;
      burst_left  = 0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_SET_BID;
      req_chan.level_price  <= '0;
      req_chan.level_volume <= '0;
      shadow_clear(SIDE_BID);
      shadow_clear(SIDE_ASK);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_sides();
      test_random_book();
      wait_book_idle();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
